>>> rtl/core/scfc_pkg.sv
// Package for the sensor frame CRC checker: frame constants, CRC-8 step,
// byte-slot decode and the result struct passed from the frame core.
// No dependencies.
package scfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 4;
  localparam int unsigned Co2W     = 32;
  localparam int unsigned TempW    = 16;
  localparam int unsigned StatusW  = 2;

  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcTop  = 8'h80;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;
  localparam logic [PosW-1:0]  FrameLast = 4'd8;

  localparam logic [StatusW-1:0] StatusOk = 2'd0;

  // Decoded role of one byte position within the frame.
  typedef struct packed {
    logic                is_check;  // CRC byte of a word
    logic                is_temp;   // byte of word three (data or check)
    logic [StatusW-1:0]  word_code; // 1..3, word this byte belongs to
  } slot_t;

  // Result candidate handed from the frame core to the result register.
  typedef struct packed {
    logic               done;
    logic [Co2W-1:0]    co2_ppm;
    logic [TempW-1:0]   temp_raw;
    logic [StatusW-1:0] status;
  } frame_res_t;

  // One byte through CRC-8, polynomial 0x31, MSB first.
  function automatic logic [ByteW-1:0] crc8_feed(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CrcTop) != '0) begin
        v = (v << 1) ^ CrcPoly;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

  // Position 0..8 to slot role; other codes are never used.
  function automatic slot_t slot_decode(input logic [PosW-1:0] pos);
    slot_t s;
    s = '{is_check: 1'b0, is_temp: 1'b0, word_code: 2'd1};
    unique case (pos)
      4'd0, 4'd1: s = '{is_check: 1'b0, is_temp: 1'b0, word_code: 2'd1};
      4'd2:       s = '{is_check: 1'b1, is_temp: 1'b0, word_code: 2'd1};
      4'd3, 4'd4: s = '{is_check: 1'b0, is_temp: 1'b0, word_code: 2'd2};
      4'd5:       s = '{is_check: 1'b1, is_temp: 1'b0, word_code: 2'd2};
      4'd6, 4'd7: s = '{is_check: 1'b0, is_temp: 1'b1, word_code: 2'd3};
      4'd8:       s = '{is_check: 1'b1, is_temp: 1'b1, word_code: 2'd3};
      default:    s = '{is_check: 1'b0, is_temp: 1'b0, word_code: 2'd1};
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/scfc_ifs.sv
// Handshake channels of the sensor frame CRC checker: received byte
// requests in, frame result requests out. Uses scfc_pkg for widths.
interface scfc_rx_if;
  logic                         valid;
  logic                         ready;
  logic [scfc_pkg::ByteW-1:0]   rx_byte;
  logic                         frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface scfc_res_if;
  logic                          valid;
  logic                          ready;
  logic [scfc_pkg::Co2W-1:0]     co2_ppm;
  logic [scfc_pkg::TempW-1:0]    temp_raw;
  logic [scfc_pkg::StatusW-1:0]  status;

  modport source (output valid, output co2_ppm, output temp_raw, output status,
                  input ready);
  modport sink   (input valid, input co2_ppm, input temp_raw, input status,
                  output ready);
endinterface

>>> rtl/core/scfc_frame_core.sv
// Frame state of the sensor frame CRC checker: byte position, running CRC,
// assembled words and first error. Depends on scfc_pkg.
module scfc_frame_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [scfc_pkg::ByteW-1:0]  byte_i,
  input  logic                        start_i,
  output scfc_pkg::frame_res_t        res_o
);

  logic [scfc_pkg::PosW-1:0]    pos_q, pos_d, pos_eff;
  logic [scfc_pkg::ByteW-1:0]   crc_q, crc_d, crc_base;
  logic [scfc_pkg::Co2W-1:0]    acc_q, acc_d, acc_base;
  logic [scfc_pkg::TempW-1:0]   temp_q, temp_d, temp_base;
  logic [scfc_pkg::StatusW-1:0] err_q, err_d, err_base;
  logic                         frame_first;
  scfc_pkg::slot_t              slot;

  always_comb begin
    pos_eff     = (start_i || pos_q > scfc_pkg::FrameLast) ? '0 : pos_q;
    frame_first = (pos_eff == '0);
    crc_base    = frame_first ? scfc_pkg::CrcInit : crc_q;
    acc_base    = frame_first ? '0 : acc_q;
    temp_base   = frame_first ? '0 : temp_q;
    err_base    = frame_first ? scfc_pkg::StatusOk : err_q;
    slot        = scfc_pkg::slot_decode(pos_eff);

    crc_d  = crc_base;
    acc_d  = acc_base;
    temp_d = temp_base;
    err_d  = err_base;
    if (!slot.is_check) begin
      crc_d = scfc_pkg::crc8_feed(crc_base, byte_i);
      if (slot.is_temp) begin
        temp_d = {temp_base[scfc_pkg::TempW-scfc_pkg::ByteW-1:0], byte_i};
      end else begin
        acc_d = {acc_base[scfc_pkg::Co2W-scfc_pkg::ByteW-1:0], byte_i};
      end
    end else begin
      // keep only the first failing word
      if (crc_base != byte_i && err_base == scfc_pkg::StatusOk) begin
        err_d = slot.word_code;
      end
      crc_d = scfc_pkg::CrcInit;
    end

    pos_d = (pos_eff == scfc_pkg::FrameLast) ? '0 : pos_eff + 4'd1;

    res_o.done     = (pos_eff == scfc_pkg::FrameLast);
    res_o.co2_ppm  = acc_d;
    res_o.temp_raw = temp_d;
    res_o.status   = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= scfc_pkg::CrcInit;
      acc_q  <= '0;
      temp_q <= '0;
      err_q  <= scfc_pkg::StatusOk;
    end else if (adv_i) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      acc_q  <= acc_d;
      temp_q <= temp_d;
      err_q  <= err_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= scfc_pkg::FrameLast)
    else $error("byte position beyond frame");

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && start_i |=> pos_q == 4'd1)
    else $error("start byte did not restart the frame");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !start_i && pos_q != '0 && pos_q != scfc_pkg::FrameLast
      && err_q != scfc_pkg::StatusOk |=> $stable(err_q))
    else $error("first error overwritten mid-frame");

endmodule

>>> rtl/core/sensor_frame_crc_checker_unit.sv
// Top level of the sensor frame CRC checker: input register, frame core and
// result register. Depends on scfc_pkg, scfc_ifs and scfc_frame_core.
//
//   channel  dir  modport  payload                         handshake
//   rx_i     in   sink     rx_byte[7:0], frame_start       valid/ready
//   res_o    out  source   co2_ppm[31:0], temp_raw[15:0],  valid/ready
//                          status[1:0]
//
// Each byte request is held in the input register; the frame core
// updates its state from that register, and the ninth byte of a frame loads
// the result register on the same edge. One byte per cycle is taken
// sustained while no ninth byte is stalled by a pending result.
// Reset (rst_ni low, asynchronous) empties both registers and sets the
// position to zero and the CRC to 0xFF.
// A result waiting in the result register stalls only a ninth byte; the
// other eight bytes of the next frame keep flowing.
module sensor_frame_crc_checker_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  scfc_rx_if.sink          rx_i,
  scfc_res_if.source       res_o
);

  // input register
  logic                               in_valid_q, in_valid_d;
  logic [scfc_pkg::ByteW-1:0]         in_byte_q;
  logic                               in_start_q;

  // result register
  logic                               out_valid_q, out_valid_d;
  logic [scfc_pkg::Co2W-1:0]          out_co2_q;
  logic [scfc_pkg::TempW-1:0]         out_temp_q;
  logic [scfc_pkg::StatusW-1:0]       out_status_q;

  scfc_pkg::frame_res_t               core_res;
  logic                               adv;
  logic                               rx_take;
  logic                               res_load;

  scfc_frame_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .res_o   (core_res)
  );

  always_comb begin
    // advance the held byte unless it finishes a frame while the result
    // register is still full and not being drained
    adv        = in_valid_q && (!core_res.done || !out_valid_q || res_o.ready);
    res_load   = adv && core_res.done;
    rx_i.ready = !in_valid_q || adv;
    rx_take    = rx_i.valid && rx_i.ready;

    in_valid_d = rx_take ? 1'b1 : (adv ? 1'b0 : in_valid_q);

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    res_o.valid    = out_valid_q;
    res_o.co2_ppm  = out_co2_q;
    res_o.temp_raw = out_temp_q;
    res_o.status   = out_status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: hold unless loaded
  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q  <= rx_i.rx_byte;
      in_start_q <= rx_i.frame_start;
    end
    if (res_load) begin
      out_co2_q    <= core_res.co2_ppm;
      out_temp_q   <= core_res.temp_raw;
      out_status_q <= core_res.status;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_load && out_valid_q && !res_o.ready))
    else $error("pending result overwritten");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> rx_i.ready)
    else $error("empty input register refused a request");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_q)
    else $error("finished frame lost");

endmodule

>>> tb/sv/scfc_frame_watch.sv
// Frame result watcher for the sensor frame CRC checker testbench: follows the
// byte requests, predicts each frame result and compares the result requests.
// Depends on scfc_pkg and the scfc_rx_if / scfc_res_if interfaces.
module scfc_frame_watch (
  input  logic clk_i,
  input  logic rst_ni,
  scfc_rx_if   rx_i,
  scfc_res_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);
  import scfc_pkg::*;

  localparam int unsigned WordSlots = 3;  // two data bytes, then the check byte
  localparam int unsigned DataSlots = 2;

  typedef struct packed {
    logic [Co2W-1:0]    co2_ppm;
    logic [TempW-1:0]   temp_raw;
    logic [StatusW-1:0] status;
  } frame_result_t;

  logic [PosW-1:0]    pos_q;
  logic [ByteW-1:0]   crc_q;
  logic [Co2W-1:0]    conc_q;
  logic [TempW-1:0]   temp_q;
  logic [StatusW-1:0] err_q;
  frame_result_t      expected_frames[$];
  int                 mismatches;

  // Shift the byte in bit by bit, MSB first.
  function automatic logic [ByteW-1:0] crc_shift_in(input logic [ByteW-1:0] crc,
                                                    input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    logic             fb;
    c = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = c[ByteW-1] ^ b[i];
      c  = {c[ByteW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return c;
  endfunction

  task automatic absorb_byte(input logic [ByteW-1:0] b, input logic st);
    logic [PosW-1:0] p;
    frame_result_t   r;
    p = (st || pos_q > FrameLast) ? '0 : pos_q;
    if (p == '0) begin
      crc_q  = CrcInit;
      conc_q = '0;
      temp_q = '0;
      err_q  = StatusOk;
    end
    if (p % WordSlots < DataSlots) begin
      crc_q = crc_shift_in(crc_q, b);
      if (p < 2 * WordSlots) begin
        conc_q = {conc_q[Co2W-ByteW-1:0], b};
      end else begin
        temp_q = {temp_q[ByteW-1:0], b};
      end
    end else begin
      if (crc_q != b && err_q == StatusOk) begin
        err_q = StatusW'(p / WordSlots + 1);
      end
      crc_q = CrcInit;
    end
    if (p == FrameLast) begin
      pos_q = '0;
      r.co2_ppm  = conc_q;
      r.temp_raw = temp_q;
      r.status   = err_q;
      expected_frames.push_back(r);
    end else begin
      pos_q = p + 1'b1;
    end
  endtask

  task automatic compare_result();
    frame_result_t e;
    if (expected_frames.size() == 0) begin
      $error("unexpected result: co2_ppm %h temp_raw %h status %0d",
             res_i.co2_ppm, res_i.temp_raw, res_i.status);
      mismatches++;
    end else begin
      e = expected_frames.pop_front();
      if (res_i.co2_ppm !== e.co2_ppm) begin
        $error("co2_ppm: expected %h, got %h", e.co2_ppm, res_i.co2_ppm);
        mismatches++;
      end
      if (res_i.temp_raw !== e.temp_raw) begin
        $error("temp_raw: expected %h, got %h", e.temp_raw, res_i.temp_raw);
        mismatches++;
      end
      if (res_i.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, res_i.status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  = '0;
      crc_q  = CrcInit;
      conc_q = '0;
      temp_q = '0;
      err_q  = StatusOk;
      expected_frames.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        absorb_byte(rx_i.rx_byte, rx_i.frame_start);
      end
      if (res_i.valid && res_i.ready) begin
        compare_result();
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_frames.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// Top of the sensor frame CRC checker testbench: clock, reset, byte request
// stimulus, result back-pressure and the verdict.
// Depends on scfc_pkg, the scfc interfaces, the unit and scfc_frame_watch.
module tb;
  import scfc_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Free-running clock, period 8.
  always #4 clk_i = ~clk_i;

  scfc_rx_if  byte_ch ();
  scfc_res_if result_ch ();

  sensor_frame_crc_checker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (byte_ch),
    .res_o  (result_ch)
  );

  int mismatches;
  int awaited;

  // Watch both channels beside the unit; it reports mismatches and the number
  // of frame results still owed.
  scfc_frame_watch watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (byte_ch),
    .res_i        (result_ch),
    .fail_count_o (mismatches),
    .pending_o    (awaited)
  );

  int idle_pct;   // chance per cycle that the byte sender holds off
  int stall_pct;  // chance per cycle that the result receiver stalls
  int sent;       // byte requests accepted so far

  // Drive result back-pressure: redraw ready on every edge at the phase's rate.
  always @(posedge clk_i) begin
    result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hand one byte request to the unit and hold it until accepted. Idle cycles
  // go in front of the request; valid stays high between back-to-back
  // requests so it never drops and rises within one step.
  task automatic push_byte(input logic [ByteW-1:0] b, input logic st);
    while ($urandom_range(0, 99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.rx_byte     <= b;
    byte_ch.frame_start <= st;
    @(posedge clk_i);
    while (!byte_ch.ready) begin
      @(posedge clk_i);
    end
    sent++;
  endtask

  // Send a word, big-endian, followed by its check byte; corrupt the check
  // byte by a nonzero XOR when asked.
  task automatic push_word(input logic [15:0] w, input logic bad, input logic st);
    logic [ByteW-1:0] crc;
    crc = crc8_feed(crc8_feed(CrcInit, w[15:8]), w[7:0]);
    if (bad) begin
      crc = crc ^ ByteW'($urandom_range(1, 255));
    end
    push_byte(w[15:8], st);
    push_byte(w[7:0], 1'b0);
    push_byte(crc, 1'b0);
  endtask

  // Send a full nine-byte frame; bad[k] corrupts the check byte of word k+1.
  task automatic push_frame(input logic [15:0] w1, input logic [15:0] w2,
                            input logic [15:0] w3, input logic [2:0] bad,
                            input logic flagged);
    push_word(w1, bad[0], flagged);
    push_word(w2, bad[1], 1'b0);
    push_word(w3, bad[2], 1'b0);
  endtask

  // Pick a word, leaning on the all-zero and all-one extremes now and then.
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    case ($urandom_range(0, 5))
      0:       w = 16'h0000;
      1:       w = 16'hFFFF;
      default: w = 16'($urandom());
    endcase
    return w;
  endfunction

  // Stop sending and wait until every owed frame result has come back.
  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One phase of random traffic: mostly whole frames with random words and
  // occasional bad check bytes, plus truncated frames and loose noise bytes.
  task automatic run_phase(input int idle, input int stall, input int n_bytes);
    int          stop_at;
    int          kind;
    int          len;
    logic [2:0]  bad;
    stop_at   = sent + n_bytes;
    idle_pct  = idle;
    stall_pct = stall;
    while (sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        for (int k = 0; k < 3; k++) begin
          bad[k] = ($urandom_range(0, 99) < 15);
        end
        // Mostly flag byte one; an unflagged frame relies on the position wrap.
        push_frame(pick_word(), pick_word(), pick_word(), bad,
                   $urandom_range(0, 9) != 0);
      end else if (kind < 85) begin
        // Truncated frame: the next flagged byte drops it without a result.
        len = $urandom_range(1, 8);
        push_byte(ByteW'($urandom()), 1'b1);
        for (int k = 1; k < len; k++) begin
          push_byte(ByteW'($urandom()), 1'b0);
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          push_byte(ByteW'($urandom()), $urandom_range(0, 3) == 0);
        end
      end
    end
    drain_results();
  endtask

  initial begin
    // Drive the byte channel to a known value before the first edge; the
    // result ready comes from the back-pressure block.
    byte_ch.valid       = 1'b0;
    byte_ch.rx_byte     = '0;
    byte_ch.frame_start = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    sent      = 0;

    // Hold reset, then release it on an edge.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a clean frame at the word extremes.
    push_frame(16'hFFFF, 16'h0000, 16'hFFFF, 3'b000, 1'b1);
    // Partial frame with a wrong check byte, dropped by the restart below.
    push_byte(8'h5A, 1'b1);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    // Restart mid-frame; words two and three both fail, so status names word
    // two only.
    push_frame(16'h0000, 16'hFFFF, 16'h0000, 3'b110, 1'b1);
    // Pause the sender until every owed result is back.
    drain_results();

    // Random traffic over the idle and stall mixes, draining after each.
    run_phase(0, 0, 108);
    run_phase(80, 0, 108);
    run_phase(0, 80, 108);
    run_phase(33, 33, 108);

    // Give a stray late result time to show up, then report.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS sensor_frame_crc_checker_unit");
    end else begin
      $display("FAIL sensor_frame_crc_checker_unit");
    end
    $finish;
  end

  // Watchdog: end a hung run well past the slowest correct one.
  initial begin
    #2000000;
    $display("FAIL sensor_frame_crc_checker_unit");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/scfc_pkg.sv
rtl/core/scfc_ifs.sv
rtl/core/scfc_frame_core.sv
rtl/core/sensor_frame_crc_checker_unit.sv
tb/sv/scfc_frame_watch.sv
tb/sv/tb.sv
